// ===== src/glu_pkg.sv =====
package glu_pkg;

  // Operand width; the ports are fixed at this width.
  localparam int OPERAND_BITS = 31;
  localparam int PRODUCT_BITS = 2 * OPERAND_BITS;

  typedef struct packed {
    logic [OPERAND_BITS-1:0] first_value;
    logic [OPERAND_BITS-1:0] second_value;
  } glu_req_t;

  typedef struct packed {
    logic [OPERAND_BITS-1:0] divisor_result;
    logic [PRODUCT_BITS-1:0] multiple_result;
    logic                    zero_operand;
  } glu_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } glu_state_t;

endpackage

// ===== src/gcd_lcm_unit.sv =====
// channel   | valid     | stall     | word
// ----------+-----------+-----------+-----------------------------------------
// request   | req_valid | req_stall | req_word : first_value, second_value
// response  | rsp_valid | rsp_stall | rsp_word : divisor, multiple, zero flag
//
// One word in flight; req_stall is high from accept until the result is taken.
// Per word, N = OPERAND_BITS: up to 2N - 2 binary GCD steps plus one to form the
// gcd, N restoring divide steps (a / gcd), N shift-add multiply steps (quotient * b).
// rsp_valid rises after the last multiply step, or with no steps at all for a zero operand;
// the next word is taken only after the result has been taken.
// Sync reset clears only the sequencer; a stalled result holds in the output register.
module gcd_lcm_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  glu_pkg::glu_req_t req_word,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output glu_pkg::glu_rsp_t rsp_word
);
  import glu_pkg::*;

  localparam int W     = OPERAND_BITS;
  localparam int CNT_W = $clog2(OPERAND_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_BITS - 1);

  glu_state_t state, state_next;

  logic [W-1:0]            a_reg;
  logic [W-1:0]            b_reg;
  logic [W-1:0]            u;
  logic [W-1:0]            v;
  logic [CNT_W-1:0]        k;
  logic [W-1:0]            g;
  logic [W-1:0]            rem;
  logic [W-1:0]            dq;
  logic [PRODUCT_BITS-1:0] acc;
  logic [CNT_W-1:0]        cnt;

  logic                    req_take;
  logic                    zero_in;
  logic                    gcd_done;
  logic                    cnt_last;
  logic [W-1:0]            u_minus_v;
  logic [W-1:0]            v_minus_u;
  logic [W:0]              div_trial;
  logic [W:0]              div_diff;
  logic                    div_bit;
  logic [W-1:0]            rem_next;
  logic [PRODUCT_BITS-1:0] acc_next;

  assign req_take = req_valid && !req_stall;
  assign zero_in  = (req_word.first_value == '0) || (req_word.second_value == '0);
  assign gcd_done = (u == v);
  assign cnt_last = (cnt == CNT_LAST);

  // Both subtractions for the GCD loop
  assign u_minus_v = u - v;
  assign v_minus_u = v - u;

  // Restoring divide step: shift in next dividend bit, try subtracting gcd
  assign div_trial = {rem, dq[W-1]};
  assign div_diff  = div_trial - {1'b0, g};
  assign div_bit   = !div_diff[W];
  assign rem_next  = div_bit ? div_diff[W-1:0] : div_trial[W-1:0];

  // Shift-add multiply step, multiplier MSB first
  assign acc_next = {acc[PRODUCT_BITS-2:0], 1'b0}
                  + (dq[W-1] ? {{(PRODUCT_BITS-W){1'b0}}, b_reg} : '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_take) state_next = zero_in ? ST_DONE : ST_GCD;
      ST_GCD:  if (gcd_done) state_next = ST_DIV;
      ST_DIV:  if (cnt_last) state_next = ST_MUL;
      ST_MUL:  if (cnt_last) state_next = ST_DONE;
      ST_DONE: if (!rsp_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req_stall = (state != ST_IDLE);
    rsp_valid = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          a_reg <= req_word.first_value;
          b_reg <= req_word.second_value;
          u     <= req_word.first_value;
          v     <= req_word.second_value;
          k     <= '0;
          if (zero_in) begin
            rsp_word.divisor_result  <= '0;
            rsp_word.multiple_result <= '0;
            rsp_word.zero_operand    <= 1'b1;
          end
        end
      end
      ST_GCD: begin
        // Binary GCD, one step per cycle
        if (gcd_done) begin
          g   <= u << k;
          rem <= '0;
          dq  <= a_reg;
          cnt <= '0;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u > v) begin
          u <= u_minus_v >> 1;
        end else begin
          v <= v_minus_u >> 1;
        end
      end
      ST_DIV: begin
        rem <= rem_next;
        dq  <= {dq[W-2:0], div_bit};
        cnt <= cnt_last ? '0 : cnt + 1'b1;
        if (cnt_last) acc <= '0;
      end
      ST_MUL: begin
        acc <= acc_next;
        dq  <= {dq[W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt_last) begin
          rsp_word.divisor_result  <= g;
          rsp_word.multiple_result <= acc_next;
          rsp_word.zero_operand    <= 1'b0;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Zero flag forces both numeric results to zero
  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.zero_operand |->
      rsp_word.divisor_result == '0 && rsp_word.multiple_result == '0)
    else $error("zero operand result not cleared");

  // A valid GCD is never zero
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_word.zero_operand |-> rsp_word.divisor_result != '0)
    else $error("zero gcd on nonzero operands");

  // GCD loop operands stay nonzero, else the loop never ends
  a_loop_live: assert property (@(posedge clk) disable iff (rst)
    state == ST_GCD |-> u != '0 && v != '0)
    else $error("gcd operand reached zero");

  // Division by the gcd is exact
  a_div_exact: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL && $past(state) == ST_DIV |-> rem == '0)
    else $error("nonzero remainder after divide");

  // Input is taken only while no result is pending
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    !req_stall |-> !rsp_valid)
    else $error("input open while result pending");

endmodule

// ===== verif/gcd_lcm_unit_tb.sv =====
module gcd_lcm_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import glu_pkg::*;

  localparam int unsigned MAX_OPERAND = (1 << OPERAND_BITS) - 1;
  localparam int          RANDOM_PER_PHASE = 260;
  localparam int          PRESSURE_WORDS = 60;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES = 200;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          MAX_REPORTS = 10;

  // Expected results of accepted request words, oldest first
  class gcd_scoreboard;
    typedef struct {
      glu_req_t operands;
      glu_rsp_t result;
    } pending_t;

    pending_t pending_q[$];
    int       failures;
    int       checked;
    int       zero_words;

    function void flag(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endfunction

    // Remainder GCD on 64 bits; lcm taken as (a / gcd) * b at product width
    function glu_rsp_t divisor_multiple(glu_req_t w);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] rem;
      logic [63:0] lcm;
      glu_rsp_t    res;
      res = '0;
      x = 64'(w.first_value);
      y = 64'(w.second_value);
      if (x == 0 || y == 0) begin
        res.zero_operand = 1'b1;
        return res;
      end
      while (y != 0) begin
        rem = x % y;
        x = y;
        y = rem;
      end
      lcm = (64'(w.first_value) / x) * 64'(w.second_value);
      res.divisor_result = x[OPERAND_BITS-1:0];
      res.multiple_result = lcm[PRODUCT_BITS-1:0];
      return res;
    endfunction

    function void note_request(glu_req_t w);
      pending_t p;
      p.operands = w;
      p.result = divisor_multiple(w);
      pending_q.insert(pending_q.size(), p);
    endfunction

    function void check_response(glu_rsp_t got);
      pending_t p;
      if (pending_q.size() == 0) begin
        flag($sformatf("response word with nothing pending: gcd %0d lcm %0d zero %0b",
                       got.divisor_result, got.multiple_result, got.zero_operand));
        return;
      end
      p = pending_q.pop_front();
      checked++;
      if (p.result.zero_operand) zero_words++;
      if (got.divisor_result !== p.result.divisor_result)
        flag($sformatf("a=%0d b=%0d gcd exp %0d got %0d", p.operands.first_value,
                       p.operands.second_value, p.result.divisor_result,
                       got.divisor_result));
      if (got.multiple_result !== p.result.multiple_result)
        flag($sformatf("a=%0d b=%0d lcm exp %0d got %0d", p.operands.first_value,
                       p.operands.second_value, p.result.multiple_result,
                       got.multiple_result));
      if (got.zero_operand !== p.result.zero_operand)
        flag($sformatf("a=%0d b=%0d zero flag exp %0b got %0b", p.operands.first_value,
                       p.operands.second_value, p.result.zero_operand,
                       got.zero_operand));
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  glu_req_t req_word = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  glu_rsp_t rsp_word;

  gcd_scoreboard sb = new();
  int            cycle_count = 0;
  int            input_stall_cycles = 0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  bit            hold_request = 1'b0;

  gcd_lcm_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_count, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Monitors: accepted words on both channels, and request stall cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req_word);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp_word);
      if (req_valid && req_stall) input_stall_cycles++;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_stall = 1'b1;
        hold_left--;
      end else begin
        rsp_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(glu_req_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_word = w;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic send_pair(int unsigned a, int unsigned b);
    glu_req_t w;
    w.first_value = a[OPERAND_BITS-1:0];
    w.second_value = b[OPERAND_BITS-1:0];
    send_word(w);
  endtask

  function automatic int unsigned any_operand();
    int unsigned r;
    r = $urandom();
    return r & MAX_OPERAND;
  endfunction

  // Operand mix: full range, shared factors, small, equal, powers of two, near max, zeros
  function automatic glu_req_t random_operands();
    int unsigned kind;
    int unsigned g;
    int unsigned a;
    int unsigned b;
    glu_req_t    w;
    kind = $urandom_range(99);
    if (kind < 5) begin
      a = ($urandom_range(2) == 0) ? 0 : any_operand();
      b = (a != 0 || $urandom_range(1) == 0) ? 0 : any_operand();
    end else if (kind < 35) begin
      a = any_operand();
      b = any_operand();
    end else if (kind < 60) begin
      g = $urandom_range(1 << 16, 1);
      a = g * $urandom_range(MAX_OPERAND / g, 1);
      b = g * $urandom_range(MAX_OPERAND / g, 1);
    end else if (kind < 75) begin
      a = $urandom_range(1000, 1);
      b = $urandom_range(1000, 1);
    end else if (kind < 85) begin
      a = $urandom_range(MAX_OPERAND, 1);
      b = a;
    end else if (kind < 92) begin
      a = 1 << $urandom_range(OPERAND_BITS - 1, 0);
      b = $urandom_range(MAX_OPERAND, 1);
    end else begin
      a = MAX_OPERAND - $urandom_range(15, 0);
      b = ($urandom_range(1) == 0) ? 1 : MAX_OPERAND - $urandom_range(15, 0);
    end
    if ($urandom_range(1) == 0) begin
      w.first_value = a[OPERAND_BITS-1:0];
      w.second_value = b[OPERAND_BITS-1:0];
    end else begin
      w.first_value = b[OPERAND_BITS-1:0];
      w.second_value = a[OPERAND_BITS-1:0];
    end
    return w;
  endfunction

  initial begin
    int send_mix[4];
    int stall_mix[4];
    send_mix = '{0, 78, 0, 25};
    stall_mix = '{0, 0, 78, 25};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero operands, unit and max values, equal primes, powers of two
    send_pair(0, 0);
    send_pair(0, 5);
    send_pair(7, 0);
    send_pair(0, MAX_OPERAND);
    send_pair(MAX_OPERAND, 0);
    send_pair(1, 1);
    send_pair(1, 2);
    send_pair(MAX_OPERAND, MAX_OPERAND);
    send_pair(MAX_OPERAND, 1);
    send_pair(1, MAX_OPERAND);
    send_pair(MAX_OPERAND, MAX_OPERAND - 1);
    send_pair(MAX_OPERAND, 1 << 30);
    send_pair(1 << 30, 1 << 30);
    send_pair(1 << 30, 1 << 29);
    send_pair(1 << 30, 3);
    send_pair(65521, 65521);
    send_pair(65521, 65519);
    send_pair(12, 18);
    send_pair(1071, 462);
    send_pair(6, 35);
    send_pair(MAX_OPERAND - 1, (MAX_OPERAND - 1) / 2);

    // Random phases with different idle patterns
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_mix[p];
      stall_pct = stall_mix[p];
      repeat (RANDOM_PER_PHASE) send_word(random_operands());
    end

    // Long receiver hold-off while the sender keeps offering words
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b1;
    repeat (PRESSURE_WORDS) send_word(random_operands());
    req_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d result words (%0d with a zero operand) in %0d cycles",
             sb.checked, sb.zero_words, cycle_count);
    $display("request side stalled %0d cycles; %0d mismatches", input_stall_cycles,
             sb.failures);
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/glu_pkg.sv
src/gcd_lcm_unit.sv
verif/gcd_lcm_unit_tb.sv
